// ===== rtl/core/ptrs_pkg.sv =====
// package for the task table scheduler
// slot states, actions, status codes, controller states and scan phases; no dependencies
`default_nettype none
package ptrs_pkg;
    localparam int SLOTS_DEF   = 64;
    localparam int ID_BITS_DEF = 16;

    typedef enum logic [2:0] {
        ST_UNUSED   = 3'd0,
        ST_RUNNABLE = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_SLEEPING = 3'd3,
        ST_ZOMBIE   = 3'd4
    } t_state;

    typedef enum logic [2:0] {
        ACT_CREATE   = 3'd0,
        ACT_SCHEDULE = 3'd1,
        ACT_YIELD    = 3'd2,
        ACT_SLEEP    = 3'd3,
        ACT_EXIT     = 3'd4,
        ACT_WAKEUP   = 3'd5,
        ACT_LOOKUP   = 3'd6
    } t_act;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_NONE      = 3'd2,
        STAT_NOCUR     = 3'd3,
        STAT_NOTFOUND  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FS_IDLE = 2'd0,
        FS_SCAN = 2'd1,
        FS_FIN  = 2'd2
    } t_fsm;

    localparam logic [1:0] PH_CAPTURE = 2'd0;
    localparam logic [1:0] PH_SEARCH  = 2'd1;
    localparam logic [1:0] PH_APPLY   = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/core/ptrs_in_if.sv =====
// request channel of the task table scheduler
// valid/ready handshake with the request fields; no dependencies
`default_nettype none
interface ptrs_in_if #(
    parameter int ID_W = 16
);
    logic            valid;
    logic            ready;
    logic [2:0]      action;
    logic [ID_W-1:0] target_pid;
    logic            user_flag;
    logic [ID_W-1:0] parent_id;

    modport source (output valid, action, target_pid, user_flag, parent_id, input ready);
    modport sink   (input valid, action, target_pid, user_flag, parent_id, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ptrs_out_if.sv =====
// result channel of the task table scheduler
// valid/ready handshake with the result fields; no dependencies
`default_nettype none
interface ptrs_out_if #(
    parameter int ID_W  = 16,
    parameter int IDX_W = 6
);
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [IDX_W-1:0] slot_index;
    logic [ID_W-1:0]  task_id;
    logic             task_is_user;
    logic             reaped;

    modport source (output valid, status, slot_index, task_id, task_is_user, reaped,
                    input ready);
    modport sink   (input valid, status, slot_index, task_id, task_is_user, reaped,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ptrs_cell.sv =====
// one slot of the task table, loaded from its neighbour on each shift
// depends on ptrs_pkg
`default_nettype none
module ptrs_cell #(
    parameter int ID_W = ptrs_pkg::ID_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_shift,
    input  wire ptrs_pkg::t_state  i_state,
    input  wire logic [ID_W-1:0]   i_id,
    input  wire logic [ID_W-1:0]   i_parent,
    input  wire logic              i_user,
    output ptrs_pkg::t_state       o_state,
    output logic [ID_W-1:0]        o_id,
    output logic [ID_W-1:0]        o_parent,
    output logic                   o_user
);
    ptrs_pkg::t_state r_state;
    logic [ID_W-1:0]  r_id;
    logic [ID_W-1:0]  r_parent;
    logic             r_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptrs_pkg::ST_UNUSED;
        end else if (i_shift) begin
            r_state <= i_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_id     <= i_id;
            r_parent <= i_parent;
            r_user   <= i_user;
        end
    end

    assign o_state  = r_state;
    assign o_id     = r_id;
    assign o_parent = r_parent;
    assign o_user   = r_user;
endmodule
`default_nettype wire

// ===== rtl/core/ptrs_chain.sv =====
// ring of slot cells; head is cell 0, the tail takes the updated head slot
// depends on ptrs_pkg and ptrs_cell
`default_nettype none
module ptrs_chain #(
    parameter int SLOTS = ptrs_pkg::SLOTS_DEF,
    parameter int ID_W  = ptrs_pkg::ID_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_shift,
    input  wire ptrs_pkg::t_state  i_state,
    input  wire logic [ID_W-1:0]   i_id,
    input  wire logic [ID_W-1:0]   i_parent,
    input  wire logic              i_user,
    output ptrs_pkg::t_state       o_state,
    output logic [ID_W-1:0]        o_id,
    output logic [ID_W-1:0]        o_parent,
    output logic                   o_user
);
    ptrs_pkg::t_state c_state  [SLOTS+1];
    logic [ID_W-1:0]  c_id     [SLOTS+1];
    logic [ID_W-1:0]  c_parent [SLOTS+1];
    logic             c_user   [SLOTS+1];

    assign c_state[SLOTS]  = i_state;
    assign c_id[SLOTS]     = i_id;
    assign c_parent[SLOTS] = i_parent;
    assign c_user[SLOTS]   = i_user;

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        ptrs_cell #(.ID_W(ID_W)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (i_shift),
            .i_state  (c_state[k+1]),
            .i_id     (c_id[k+1]),
            .i_parent (c_parent[k+1]),
            .i_user   (c_user[k+1]),
            .o_state  (c_state[k]),
            .o_id     (c_id[k]),
            .o_parent (c_parent[k]),
            .o_user   (c_user[k])
        );
    end

    assign o_state  = c_state[0];
    assign o_id     = c_id[0];
    assign o_parent = c_parent[0];
    assign o_user   = c_user[0];
endmodule
`default_nettype wire

// ===== rtl/core/process_table_round_robin_scheduler.sv =====
// task table with round-robin scheduling over a rotating ring of slot cells
// each item goes round the ring in capture, search and apply passes, in that order
// a new item is taken only once the last is finished, the ring rotating one slot a cycle while scanning
// a finished result waits in the output register while the next item is taken
// reset: all slots unused, pointer 0, next id 1, no current task
// depends on ptrs_pkg, ptrs_in_if, ptrs_out_if, ptrs_chain
`default_nettype none
module process_table_round_robin_scheduler #(
    parameter int SLOTS   = ptrs_pkg::SLOTS_DEF,
    parameter int ID_BITS = ptrs_pkg::ID_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ptrs_in_if.sink    i_in,
    ptrs_out_if.source o_out
);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    ptrs_pkg::t_fsm r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_phase, n_phase;

    logic [2:0]         r_act;
    logic [ID_BITS-1:0] r_tgt, r_par, r_cpar, n_cpar;
    logic               r_user;

    logic [IDX_W-1:0]   r_rr, n_rr, r_cur, n_cur, r_sel, n_sel, r_selhi, n_selhi;
    logic               r_curv, n_curv, r_fnd, n_fnd, r_fndhi, n_fndhi, r_live, n_live;
    logic [ID_BITS-1:0] r_nid, n_nid, r_oid, n_oid;
    logic               r_ouser, n_ouser;

    logic               r_ov, n_ov;
    ptrs_pkg::t_status  r_ostat, n_ostat;
    logic [IDX_W-1:0]   r_oslot, n_oslot;
    logic [ID_BITS-1:0] r_otid, n_otid;
    logic               r_otu, n_otu, r_orp, n_orp;

    ptrs_pkg::t_state   h_state, t_state_w;
    logic [ID_BITS-1:0] h_id, h_parent, t_id, t_parent;
    logic               h_user, t_user;

    logic               accept, shift, load;
    logic               e_fnd, reap, cand;
    logic [IDX_W-1:0]   e_sel;

    assign accept = i_in.valid && i_in.ready;
    assign shift  = (r_state == ptrs_pkg::FS_SCAN);
    assign load   = (r_state == ptrs_pkg::FS_FIN) && (!r_ov || o_out.ready);

    ptrs_chain #(.SLOTS(SLOTS), .ID_W(ID_BITS)) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (shift),
        .i_state  (t_state_w),
        .i_id     (t_id),
        .i_parent (t_parent),
        .i_user   (t_user),
        .o_state  (h_state),
        .o_id     (h_id),
        .o_parent (h_parent),
        .o_user   (h_user)
    );

    // chosen slot and reap decision
    always_comb begin
        e_fnd = r_fnd;
        e_sel = r_sel;
        case (r_act)
            ptrs_pkg::ACT_SCHEDULE: begin
                if (r_fndhi) begin
                    e_sel = r_selhi;
                end
            end
            ptrs_pkg::ACT_YIELD, ptrs_pkg::ACT_SLEEP, ptrs_pkg::ACT_EXIT: begin
                e_fnd = r_curv;
                e_sel = r_cur;
            end
            default: begin
            end
        endcase
        reap = (r_act == ptrs_pkg::ACT_EXIT) && ((r_cpar == '0) || !r_live);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptrs_pkg::FS_IDLE: begin
                if (accept) begin
                    n_state = ptrs_pkg::FS_SCAN;
                end
            end
            ptrs_pkg::FS_SCAN: begin
                if (r_cnt == LAST && r_phase == ptrs_pkg::PH_APPLY) begin
                    n_state = ptrs_pkg::FS_FIN;
                end
            end
            ptrs_pkg::FS_FIN: begin
                if (load) begin
                    n_state = ptrs_pkg::FS_IDLE;
                end
            end
            default: n_state = ptrs_pkg::FS_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_cnt   = r_cnt;
        n_phase = r_phase;
        n_cpar  = r_cpar;
        n_sel   = r_sel;
        n_fnd   = r_fnd;
        n_selhi = r_selhi;
        n_fndhi = r_fndhi;
        n_live  = r_live;
        n_oid   = r_oid;
        n_ouser = r_ouser;
        n_rr    = r_rr;
        n_cur   = r_cur;
        n_curv  = r_curv;
        n_nid   = r_nid;
        n_ov    = r_ov;
        n_ostat = r_ostat;
        n_oslot = r_oslot;
        n_otid  = r_otid;
        n_otu   = r_otu;
        n_orp   = r_orp;
        t_state_w = h_state;
        t_id      = h_id;
        t_parent  = h_parent;
        t_user    = h_user;
        cand      = 1'b0;

        if (accept) begin
            n_cnt   = '0;
            n_phase = ptrs_pkg::PH_CAPTURE;
            n_fnd   = 1'b0;
            n_fndhi = 1'b0;
            n_live  = 1'b0;
            n_sel   = '0;
            n_selhi = '0;
            n_cpar  = '0;
        end

        if (shift) begin
            if (r_cnt == LAST) begin
                n_cnt   = '0;
                n_phase = r_phase + 2'd1;
            end else begin
                n_cnt = r_cnt + IDX_W'(1);
            end

            case (r_phase)
                ptrs_pkg::PH_CAPTURE: begin
                    if (r_curv && r_cnt == r_cur) begin
                        n_cpar = h_parent;
                    end
                end
                ptrs_pkg::PH_SEARCH: begin
                    case (r_act)
                        ptrs_pkg::ACT_CREATE:
                            cand = (h_state == ptrs_pkg::ST_UNUSED);
                        ptrs_pkg::ACT_SCHEDULE:
                            cand = (h_state == ptrs_pkg::ST_RUNNABLE)
                                || (r_curv && r_cnt == r_cur);
                        ptrs_pkg::ACT_WAKEUP:
                            cand = (h_state == ptrs_pkg::ST_SLEEPING) && (h_id == r_tgt);
                        ptrs_pkg::ACT_LOOKUP:
                            cand = (h_state != ptrs_pkg::ST_UNUSED) && (h_id == r_tgt);
                        default: cand = 1'b0;
                    endcase
                    if (cand && !r_fnd) begin
                        n_fnd = 1'b1;
                        n_sel = r_cnt;
                    end
                    if (cand && !r_fndhi && r_cnt >= r_rr) begin
                        n_fndhi = 1'b1;
                        n_selhi = r_cnt;
                    end
                    if (h_state != ptrs_pkg::ST_UNUSED && h_id == r_cpar) begin
                        n_live = 1'b1;
                    end
                end
                ptrs_pkg::PH_APPLY: begin
                    if (e_fnd && r_cnt == e_sel) begin
                        n_oid   = h_id;
                        n_ouser = h_user;
                    end
                    case (r_act)
                        ptrs_pkg::ACT_CREATE: begin
                            if (e_fnd && r_cnt == e_sel) begin
                                t_state_w = ptrs_pkg::ST_RUNNABLE;
                                t_id      = r_nid;
                                t_parent  = r_par;
                                t_user    = r_user;
                            end
                        end
                        ptrs_pkg::ACT_SCHEDULE: begin
                            if (e_fnd && r_cnt == e_sel) begin
                                t_state_w = ptrs_pkg::ST_RUNNING;
                            end else if (r_curv && r_cnt == r_cur) begin
                                t_state_w = ptrs_pkg::ST_RUNNABLE;
                            end
                        end
                        ptrs_pkg::ACT_YIELD: begin
                            if (r_curv && r_cnt == r_cur) begin
                                t_state_w = ptrs_pkg::ST_RUNNABLE;
                            end
                        end
                        ptrs_pkg::ACT_SLEEP: begin
                            if (r_curv && r_cnt == r_cur) begin
                                t_state_w = ptrs_pkg::ST_SLEEPING;
                            end
                        end
                        ptrs_pkg::ACT_EXIT: begin
                            if (r_curv && r_cnt == r_cur) begin
                                if (reap) begin
                                    t_state_w = ptrs_pkg::ST_UNUSED;
                                    t_id      = '0;
                                    t_parent  = '0;
                                    t_user    = 1'b0;
                                end else begin
                                    t_state_w = ptrs_pkg::ST_ZOMBIE;
                                end
                            end
                        end
                        ptrs_pkg::ACT_WAKEUP: begin
                            if (h_state == ptrs_pkg::ST_SLEEPING && h_id == r_tgt) begin
                                t_state_w = ptrs_pkg::ST_RUNNABLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        if (o_out.ready) begin
            n_ov = 1'b0;
        end

        if (load) begin
            n_ov    = 1'b1;
            n_ostat = ptrs_pkg::STAT_OK;
            n_oslot = '0;
            n_otid  = '0;
            n_otu   = 1'b0;
            n_orp   = 1'b0;
            case (r_act)
                ptrs_pkg::ACT_CREATE: begin
                    if (e_fnd) begin
                        n_oslot = e_sel;
                        n_otid  = r_nid;
                        n_otu   = r_user;
                        n_nid   = (r_nid == '1) ? ID_BITS'(1) : r_nid + ID_BITS'(1);
                    end else begin
                        n_ostat = ptrs_pkg::STAT_FULL;
                    end
                end
                ptrs_pkg::ACT_SCHEDULE: begin
                    if (e_fnd) begin
                        n_oslot = e_sel;
                        n_otid  = r_oid;
                        n_otu   = r_ouser;
                        n_rr    = (e_sel == LAST) ? '0 : e_sel + IDX_W'(1);
                        n_cur   = e_sel;
                        n_curv  = 1'b1;
                    end else begin
                        n_ostat = ptrs_pkg::STAT_NONE;
                        n_curv  = 1'b0;
                    end
                end
                ptrs_pkg::ACT_YIELD, ptrs_pkg::ACT_SLEEP, ptrs_pkg::ACT_EXIT: begin
                    if (r_curv) begin
                        n_oslot = r_cur;
                        n_otid  = r_oid;
                        n_otu   = r_ouser;
                        n_orp   = reap;
                        n_curv  = 1'b0;
                    end else begin
                        n_ostat = ptrs_pkg::STAT_NOCUR;
                    end
                end
                ptrs_pkg::ACT_WAKEUP, ptrs_pkg::ACT_LOOKUP: begin
                    if (e_fnd) begin
                        n_oslot = e_sel;
                        n_otid  = r_oid;
                        n_otu   = r_ouser;
                    end else begin
                        n_ostat = ptrs_pkg::STAT_NOTFOUND;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptrs_pkg::FS_IDLE;
            r_cnt   <= '0;
            r_phase <= ptrs_pkg::PH_CAPTURE;
            r_rr    <= '0;
            r_cur   <= '0;
            r_curv  <= 1'b0;
            r_nid   <= ID_BITS'(1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
            r_rr    <= n_rr;
            r_cur   <= n_cur;
            r_curv  <= n_curv;
            r_nid   <= n_nid;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_in.action;
            r_tgt  <= i_in.target_pid;
            r_user <= i_in.user_flag;
            r_par  <= i_in.parent_id;
        end
        r_cpar  <= n_cpar;
        r_sel   <= n_sel;
        r_fnd   <= n_fnd;
        r_selhi <= n_selhi;
        r_fndhi <= n_fndhi;
        r_live  <= n_live;
        r_oid   <= n_oid;
        r_ouser <= n_ouser;
        r_ostat <= n_ostat;
        r_oslot <= n_oslot;
        r_otid  <= n_otid;
        r_otu   <= n_otu;
        r_orp   <= n_orp;
    end

    // outputs
    always_comb begin
        i_in.ready         = (r_state == ptrs_pkg::FS_IDLE);
        o_out.valid        = r_ov;
        o_out.status       = r_ostat;
        o_out.slot_index   = r_oslot;
        o_out.task_id      = r_otid;
        o_out.task_is_user = r_otu;
        o_out.reaped       = r_orp;
    end

    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_cnt == '0))
        else $error("scan counter not at rest while idle");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ptrs_pkg::STAT_OK)
        |-> (o_out.slot_index == '0 && o_out.task_id == '0 && !o_out.reaped))
        else $error("failed result carries slot fields");
    a_reap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && reap && r_curv |=> !r_curv)
        else $error("current task kept after exit");
    a_fin_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ptrs_pkg::FS_FIN) |-> $past(r_phase) == ptrs_pkg::PH_APPLY)
        else $error("result finished before the apply pass");
endmodule
`default_nettype wire

// ===== tb/sv/ptrs_tb_checker.sv =====
// checker for the task table scheduler testbench
// watches both channels, keeps its own copy of the task table and compares results
// depends on ptrs_pkg, ptrs_in_if, ptrs_out_if
`default_nettype none
module ptrs_tb_checker #(
    parameter int SLOTS   = 64,
    parameter int ID_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ptrs_in_if        i_in,
    ptrs_out_if       i_out,
    output int        o_errors,
    output int        o_pending,
    output int        o_results
);
    import ptrs_pkg::*;

    typedef bit bool_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         slot_index;
        logic [ID_BITS-1:0] task_id;
        logic               task_is_user;
        logic               reaped;
    } t_result;

    t_state             tbl_state  [SLOTS];
    logic [ID_BITS-1:0] tbl_id     [SLOTS];
    logic [ID_BITS-1:0] tbl_parent [SLOTS];
    logic               tbl_user   [SLOTS];
    int                 rr_ptr;
    logic [ID_BITS-1:0] id_counter;
    logic               cur_valid;
    int                 cur_slot;
    t_result            expected_results[$];

    assign o_pending = expected_results.size();

    function automatic t_result slot_result(int s);
        t_result r;
        r = '0;
        r.slot_index = s[5:0];
        r.task_id = tbl_id[s];
        r.task_is_user = tbl_user[s];
        return r;
    endfunction

    function automatic t_result fail_result(t_status st);
        t_result r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic void clear_slot(int s);
        tbl_state[s] = ST_UNUSED;
        tbl_id[s] = '0;
        tbl_parent[s] = '0;
        tbl_user[s] = 1'b0;
    endfunction

    function automatic t_result predict_action(logic [2:0] act, logic [ID_BITS-1:0] target,
                                               logic user, logic [ID_BITS-1:0] parent);
        t_result r;
        int idx;
        int s;
        bool_t live;
        r = '0;
        case (act)
            ACT_CREATE: begin
                r = fail_result(STAT_FULL);
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_state[i] == ST_UNUSED) begin
                        tbl_id[i] = id_counter;
                        id_counter = id_counter + 1'b1;
                        if (id_counter == '0) id_counter = ID_BITS'(1);
                        tbl_parent[i] = parent;
                        tbl_user[i] = user;
                        tbl_state[i] = ST_RUNNABLE;
                        return slot_result(i);
                    end
                end
            end
            ACT_SCHEDULE: begin
                if (cur_valid) begin
                    tbl_state[cur_slot] = ST_RUNNABLE;
                    cur_valid = 1'b0;
                end
                r = fail_result(STAT_NONE);
                for (int i = 0; i < SLOTS; i++) begin
                    idx = (rr_ptr + i) % SLOTS;
                    if (tbl_state[idx] == ST_RUNNABLE) begin
                        tbl_state[idx] = ST_RUNNING;
                        rr_ptr = (idx + 1) % SLOTS;
                        cur_valid = 1'b1;
                        cur_slot = idx;
                        return slot_result(idx);
                    end
                end
            end
            ACT_YIELD, ACT_SLEEP, ACT_EXIT: begin
                if (!cur_valid) return fail_result(STAT_NOCUR);
                s = cur_slot;
                cur_valid = 1'b0;
                r = slot_result(s);
                if (act == ACT_YIELD) tbl_state[s] = ST_RUNNABLE;
                else if (act == ACT_SLEEP) tbl_state[s] = ST_SLEEPING;
                else begin
                    tbl_state[s] = ST_ZOMBIE;
                    live = 0;
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_state[i] != ST_UNUSED && tbl_id[i] == tbl_parent[s]) live = 1;
                    if (tbl_parent[s] == '0 || !live) begin
                        clear_slot(s);
                        r.reaped = 1'b1;
                    end
                end
            end
            ACT_WAKEUP: begin
                r = fail_result(STAT_NOTFOUND);
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (tbl_state[i] == ST_SLEEPING && tbl_id[i] == target) begin
                        tbl_state[i] = ST_RUNNABLE;
                        r = slot_result(i);
                    end
                end
            end
            ACT_LOOKUP: begin
                r = fail_result(STAT_NOTFOUND);
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (tbl_state[i] != ST_UNUSED && tbl_id[i] == target) r = slot_result(i);
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", o_results, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) clear_slot(i);
            rr_ptr = 0;
            id_counter = ID_BITS'(1);
            cur_valid = 1'b0;
            cur_slot = 0;
            expected_results.delete();
            o_errors = 0;
            o_results = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.status, i_out.slot_index, i_out.task_id, i_out.task_is_user,
                        i_out.reaped};
                if (expected_results.size() == 0) begin
                    $display("result with none expected");
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.slot_index !== want.slot_index)
                        report_mismatch("slot_index", got.slot_index, want.slot_index);
                    if (got.task_id !== want.task_id)
                        report_mismatch("task_id", got.task_id, want.task_id);
                    if (got.task_is_user !== want.task_is_user)
                        report_mismatch("task_is_user", got.task_is_user, want.task_is_user);
                    if (got.reaped !== want.reaped)
                        report_mismatch("reaped", got.reaped, want.reaped);
                end
                o_results++;
            end
            if (i_in.valid && i_in.ready)
                expected_results.push_back(predict_action(i_in.action, i_in.target_pid,
                                                          i_in.user_flag, i_in.parent_id));
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/process_table_round_robin_scheduler_tb.sv =====
// top of the task table scheduler testbench: clock, reset, stimulus and verdict
// directed task sequences then random ones, with random idling on both channels
// depends on ptrs_pkg, ptrs_in_if, ptrs_out_if, ptrs_tb_checker and the block
`default_nettype none
module process_table_round_robin_scheduler_tb;
    import ptrs_pkg::*;

    localparam int SLOTS     = 64;
    localparam int ID_BITS   = 16;
    localparam int N_RANDOM  = 2000;
    localparam int WATCHDOG  = 20 * (3 * SLOTS + 2) + 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   results;
    int   idle_cycles = 0;
    bit   quiet = 1'b0;
    int   sent = 0;

    ptrs_in_if  #(.ID_W(ID_BITS)) in_ch ();
    ptrs_out_if #(.ID_W(ID_BITS), .IDX_W(6)) out_ch ();

    process_table_round_robin_scheduler #(.SLOTS(SLOTS), .ID_BITS(ID_BITS)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    ptrs_tb_checker #(.SLOTS(SLOTS), .ID_BITS(ID_BITS)) checker_inst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (in_ch),
        .i_out    (out_ch),
        .o_errors (errors),
        .o_pending(pending),
        .o_results(results)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = '0;
        in_ch.target_pid = '0;
        in_ch.user_flag = 1'b0;
        in_ch.parent_id = '0;
        out_ch.ready = 1'b0;
    end

    // result side stalls in bursts
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            out_ch.ready <= 1'b1;
            n = $urandom_range(1, 40);
            repeat (n) @(posedge i_clk);
            if (!quiet && $urandom_range(0, 1)) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("timeout with %0d results outstanding", pending);
            $display("process_table_round_robin_scheduler_tb failed");
            $finish;
        end
    end

    task automatic send_item(t_act act, logic [ID_BITS-1:0] target, logic user,
                             logic [ID_BITS-1:0] parent);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.target_pid <= target;
        in_ch.user_flag <= user;
        in_ch.parent_id <= parent;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic [ID_BITS-1:0] pick_id();
        case ($urandom_range(0, 5))
            0: return ID_BITS'($urandom);
            1: return '0;
            2: return '1;
            default: return ID_BITS'($urandom_range(1, 80));
        endcase
    endfunction

    initial begin
        t_act act;
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table cases, then a small family of tasks
        send_item(ACT_SCHEDULE, '0, 1'b0, '0);
        send_item(ACT_YIELD, '0, 1'b0, '0);
        send_item(ACT_SLEEP, '0, 1'b0, '0);
        send_item(ACT_EXIT, '0, 1'b0, '0);
        send_item(ACT_WAKEUP, 16'hFFFF, 1'b0, '0);
        send_item(ACT_LOOKUP, '0, 1'b0, '0);
        send_item(t_act'(3'd7), 16'hFFFF, 1'b1, 16'hFFFF);
        send_item(ACT_CREATE, '0, 1'b1, '0);
        send_item(ACT_CREATE, '0, 1'b0, 16'd1);
        send_item(ACT_CREATE, 16'hFFFF, 1'b1, 16'hFFFF);
        send_item(ACT_LOOKUP, 16'd2, 1'b0, '0);
        send_item(ACT_SCHEDULE, '0, 1'b0, '0);
        send_item(ACT_SCHEDULE, '0, 1'b0, '0);
        send_item(ACT_SLEEP, '0, 1'b0, '0);
        send_item(ACT_WAKEUP, 16'd2, 1'b0, '0);
        send_item(ACT_SCHEDULE, '0, 1'b0, '0);
        send_item(ACT_EXIT, '0, 1'b0, '0);
        send_item(ACT_SCHEDULE, '0, 1'b0, '0);
        send_item(ACT_EXIT, '0, 1'b0, '0);
        send_item(ACT_SCHEDULE, '0, 1'b0, '0);
        send_item(ACT_YIELD, '0, 1'b0, '0);

        // fill the table to overflow, then random traffic
        for (int i = 0; i < SLOTS + 2; i++)
            send_item(ACT_CREATE, '0, 1'($urandom_range(0, 1)), pick_id());
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i > N_RANDOM - 150) quiet = 1'b1;
            k = $urandom_range(0, 99);
            if (k < 22) act = ACT_CREATE;
            else if (k < 42) act = ACT_SCHEDULE;
            else if (k < 50) act = ACT_YIELD;
            else if (k < 60) act = ACT_SLEEP;
            else if (k < 76) act = ACT_EXIT;
            else if (k < 86) act = ACT_WAKEUP;
            else if (k < 97) act = ACT_LOOKUP;
            else act = t_act'(3'd7);
            send_item(act, pick_id(), 1'($urandom_range(0, 1)), pick_id());
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (3 * SLOTS + 10) @(posedge i_clk);
        $display("sent %0d task table requests, %0d results checked", sent, results);
        $display("covered create to overflow, scheduling, retiring, wakeup, lookup and reaping");
        if (errors == 0) begin
            $display("process_table_round_robin_scheduler_tb passed");
        end else begin
            $display("process_table_round_robin_scheduler_tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
